@@ rtl/qgi_pkg.sv @@
package qgi_pkg;

  // Step of the Euler integration as a power of two, in seconds.
  localparam int DT_SHIFT   = 9;
  localparam int RATE_W     = 24;
  localparam int W_W        = 25;
  localparam int Q_W        = 32;
  localparam int OP_W       = 33;
  localparam int PROD_W     = 2 * OP_W;
  localparam int ACC_W      = 60;
  localparam int SS_W       = 63;
  localparam int ROOT_W     = 32;
  localparam int ERR_SHIFT  = 12;
  localparam int D_SHIFT    = 17 + DT_SHIFT;
  localparam int NXT_W      = Q_W + 3;
  localparam int CFG_IDX_W  = 2;
  localparam int ROT_TERMS  = 12;
  localparam int CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z = 2'd2;

  localparam logic signed [Q_W-1:0] Q_ONE    = 32'sh4000_0000;
  localparam logic signed [OP_W-1:0] NORM_ONE = 33'sh0_2000_0000;
  localparam logic signed [NXT_W-1:0] Q_MAX   = 35'sh0_7FFF_FFFF;
  localparam logic signed [NXT_W-1:0] Q_MIN   = -35'sh0_8000_0000;

  typedef enum logic [1:0] {
    MK_SQUARE,
    MK_ROT,
    MK_NORM
  } mul_kind_e;

  typedef struct packed {
    logic      valid;
    mul_kind_e kind;
    logic [1:0] dest;
    logic      neg;
  } mul_tag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_ROT,
    ST_ROT_WAIT,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0] w_sel;
    logic [1:0] q_sel;
    logic [1:0] dest;
    logic       neg;
  } rot_term_t;

  // Terms of 0.5 * q (x) (0, w), one product each.
  function automatic rot_term_t rot_term(input logic [CNT_W-1:0] k);
    rot_term_t t;
    case (k)
      4'd0:    t = '{w_sel: 2'd0, q_sel: 2'd1, dest: 2'd0, neg: 1'b1};
      4'd1:    t = '{w_sel: 2'd1, q_sel: 2'd2, dest: 2'd0, neg: 1'b1};
      4'd2:    t = '{w_sel: 2'd2, q_sel: 2'd3, dest: 2'd0, neg: 1'b1};
      4'd3:    t = '{w_sel: 2'd0, q_sel: 2'd0, dest: 2'd1, neg: 1'b0};
      4'd4:    t = '{w_sel: 2'd2, q_sel: 2'd2, dest: 2'd1, neg: 1'b0};
      4'd5:    t = '{w_sel: 2'd1, q_sel: 2'd3, dest: 2'd1, neg: 1'b1};
      4'd6:    t = '{w_sel: 2'd1, q_sel: 2'd0, dest: 2'd2, neg: 1'b0};
      4'd7:    t = '{w_sel: 2'd2, q_sel: 2'd1, dest: 2'd2, neg: 1'b1};
      4'd8:    t = '{w_sel: 2'd0, q_sel: 2'd3, dest: 2'd2, neg: 1'b0};
      4'd9:    t = '{w_sel: 2'd2, q_sel: 2'd0, dest: 2'd3, neg: 1'b0};
      4'd10:   t = '{w_sel: 2'd1, q_sel: 2'd1, dest: 2'd3, neg: 1'b0};
      4'd11:   t = '{w_sel: 2'd0, q_sel: 2'd2, dest: 2'd3, neg: 1'b1};
      default: t = '{w_sel: 2'd0, q_sel: 2'd0, dest: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

@@ rtl/qgi_if.sv @@
// Gyro sample channel.
interface qgi_rate_if;
  import qgi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;
  modport source (output valid, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

// Attitude result channel.
interface qgi_quat_if;
  import qgi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] quat_w;
  logic signed [Q_W-1:0] quat_x;
  logic signed [Q_W-1:0] quat_y;
  logic signed [Q_W-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// Register write channel.
interface qgi_cfg_if;
  import qgi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RATE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/qgi_mul.sv @@
module qgi_mul
  import qgi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [OP_W-1:0]   a_i,
  input  logic signed [OP_W-1:0]   b_i,
  input  mul_tag_t                 tag_i,
  output logic signed [PROD_W-1:0] prod_o,
  output mul_tag_t                 tag_o
);

  logic signed [PROD_W-1:0] prod_q;
  mul_tag_t                 tag_q;

  // The product register carries no reset; its tag says when it is valid.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

@@ rtl/qgi_isqrt.sv @@
module qgi_isqrt
  import qgi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SS_W-1:0]   n_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  step_q;
  logic [63:0] rem_q;
  logic [63:0] res_q;
  logic [63:0] bitv;
  logic [63:0] trial;

  // One result bit per cycle, highest first.
  assign bitv  = 64'd1 << {step_q, 1'b0};
  assign trial = res_q + bitv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 5'd31;
      end else if (busy_q) begin
        step_q <= step_q - 5'd1;
        if (step_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, n_i};
      res_q <= '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

@@ rtl/quaternion_gyro_integrator.sv @@
// Channel   Port    Direction  Word
// gyro      rate_i  in         rate_x, rate_y, rate_z (Q8.16)
// attitude  quat_o  out        quat_w, quat_x, quat_y, quat_z (Q2.30)
// config    cfg_i   in         index, data (bias x, y, z)
//
// The result word is offered once the sample has passed through the shared
// multiplier (4 squares, 16 products) and the 32-step square root.
// rate_i is ready only while idle; a finished word waits on quat_o until taken.
// Reset clears the biases and sets the identity attitude.
// cfg_i is always ready; writes are meant for idle periods.
module quaternion_gyro_integrator
  import qgi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  qgi_rate_if.sink   rate_i,
  qgi_quat_if.source quat_o,
  qgi_cfg_if.sink    cfg_i
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [RATE_W-1:0] bias_q [3];
  logic signed [W_W-1:0]    w_q [3];
  logic signed [Q_W-1:0]    q_q [4];
  logic signed [ACC_W-1:0]  d_q [4];
  logic [SS_W-1:0]          ss_q;
  logic signed [OP_W-1:0]   err_q;

  logic signed [OP_W-1:0]   op_a, op_b;
  mul_tag_t                 tag_in, tag_out;
  logic signed [PROD_W-1:0] prod;
  rot_term_t                term;
  logic                     root_go, root_done;
  logic [ROOT_W-1:0]        root;
  logic                     accept;

  assign accept = rate_i.valid && rate_i.ready;

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q[0] <= '0;
      bias_q[1] <= '0;
      bias_q[2] <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BIAS_X: bias_q[0] <= cfg_i.data;
        REG_BIAS_Y: bias_q[1] <= cfg_i.data;
        REG_BIAS_Z: bias_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = '0;
    root_go      = 1'b0;
    rate_i.ready = 1'b0;
    quat_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rate_i.ready = 1'b1;
        if (rate_i.valid) state_d = ST_SQ;
      end
      ST_SQ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) state_d = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: state_d = ST_ROOT_GO;
      ST_ROOT_GO: begin
        root_go = 1'b1;
        state_d = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (root_done) state_d = ST_ROT;
      end
      ST_ROT: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = ST_ROT_WAIT;
      end
      ST_ROT_WAIT: state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_OUT;
      ST_OUT: begin
        quat_o.valid = 1'b1;
        if (quat_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    term   = rot_term(cnt_q);
    op_a   = '0;
    op_b   = '0;
    tag_in = '0;
    case (state_q)
      ST_SQ: begin
        op_a   = OP_W'(q_q[cnt_q[1:0]]);
        op_b   = OP_W'(q_q[cnt_q[1:0]]);
        tag_in = '{valid: 1'b1, kind: MK_SQUARE, dest: cnt_q[1:0], neg: 1'b0};
      end
      ST_ROT: begin
        if (cnt_q < 4'(ROT_TERMS)) begin
          op_a   = OP_W'(w_q[term.w_sel]);
          op_b   = OP_W'(q_q[term.q_sel]);
          tag_in = '{valid: 1'b1, kind: MK_ROT, dest: term.dest, neg: term.neg};
        end else begin
          op_a   = err_q;
          op_b   = OP_W'(q_q[cnt_q[1:0]]);
          tag_in = '{valid: 1'b1, kind: MK_NORM, dest: cnt_q[1:0], neg: 1'b0};
        end
      end
      default: ;
    endcase
  end

  qgi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (op_a),
    .b_i    (op_b),
    .tag_i  (tag_in),
    .prod_o (prod),
    .tag_o  (tag_out)
  );

  qgi_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_go),
    .n_i     (ss_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Working registers: unbiased rates, accumulators and the norm error.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q[0] <= W_W'(rate_i.rate_x) - W_W'(bias_q[0]);
      w_q[1] <= W_W'(rate_i.rate_y) - W_W'(bias_q[1]);
      w_q[2] <= W_W'(rate_i.rate_z) - W_W'(bias_q[2]);
      ss_q   <= '0;
      for (int i = 0; i < 4; i++) d_q[i] <= '0;
    end else if (tag_out.valid) begin
      case (tag_out.kind)
        MK_SQUARE: ss_q <= ss_q + prod[SS_W+1:2];
        MK_ROT: begin
          if (tag_out.neg) d_q[tag_out.dest] <= d_q[tag_out.dest] - ACC_W'(prod);
          else             d_q[tag_out.dest] <= d_q[tag_out.dest] + ACC_W'(prod);
        end
        MK_NORM: d_q[tag_out.dest] <= d_q[tag_out.dest] + ACC_W'(prod >>> ERR_SHIFT);
        default: ;
      endcase
    end
    if (root_done) begin
      err_q <= NORM_ONE - $signed({1'b0, root});
    end
  end

  // Euler step with saturation, all four parts at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= Q_ONE;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
    end else if (state_q == ST_UPDATE) begin
      for (int i = 0; i < 4; i++) begin
        logic signed [NXT_W-1:0] nxt;
        nxt = NXT_W'(q_q[i]) + NXT_W'(d_q[i] >>> D_SHIFT);
        if (nxt > Q_MAX)      q_q[i] <= Q_MAX[Q_W-1:0];
        else if (nxt < Q_MIN) q_q[i] <= Q_MIN[Q_W-1:0];
        else                  q_q[i] <= nxt[Q_W-1:0];
      end
    end
  end

  assign quat_o.quat_w = q_q[0];
  assign quat_o.quat_x = q_q[1];
  assign quat_o.quat_y = q_q[2];
  assign quat_o.quat_z = q_q[3];

  // A sample is never taken while a word is still on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rate_i.ready && quat_o.valid))
    else $error("input ready while a result waits");

  // An accepted sample starts the squaring pass on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SQ)
    else $error("sequencer did not start after acceptance");

  // The root only completes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == ST_ROOT_WAIT)
    else $error("square root finished outside its wait state");

endmodule
